// ===== src/lier_pkg.sv =====
// package with ring sizing, character widths, register indexes and pointer helpers
`default_nettype none
package lier_pkg;

  localparam int RING_DEPTH = 128;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CHAR_W     = 7;
  localparam int KEY_W      = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE   = 1'b1;

  localparam logic [CHAR_W-1:0] BACKSPACE_RESET = 7'd8;
  localparam logic [CHAR_W-1:0] NEWLINE_RESET   = 7'd10;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    logic  wr_en;
    ptr_t  wr_addr;
    char_t wr_data;
    logic  rd_en;
    ptr_t  rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic  echo_valid;
    char_t echo_char;
    logic  key_dropped;
    logic  read_valid;
  } result_t;

  function automatic ptr_t ring_next(input ptr_t p);
    return (p == PTR_LAST) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ring_prev(input ptr_t p);
    return (p == '0) ? PTR_LAST : ptr_t'(p - 1'b1);
  endfunction

endpackage
`default_nettype wire

// ===== src/lier_if.sv =====
// valid/ready channel interfaces for key/read items and results
`default_nettype none
interface lier_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [lier_pkg::KEY_W-1:0]   key_char;

  modport source (output valid, output operation, output key_char, input ready);
  modport sink   (input valid, input operation, input key_char, output ready);
endinterface

interface lier_out_if;
  logic                         valid;
  logic                         ready;
  logic                         echo_valid;
  logic [lier_pkg::CHAR_W-1:0]  echo_char;
  logic                         key_dropped;
  logic                         read_valid;
  logic [lier_pkg::CHAR_W-1:0]  read_char;
  logic                         read_end_of_line;

  modport source (output valid, output echo_valid, output echo_char, output key_dropped,
                  output read_valid, output read_char, output read_end_of_line,
                  input ready);
  modport sink   (input valid, input echo_valid, input echo_char, input key_dropped,
                  input read_valid, input read_char, input read_end_of_line,
                  output ready);
endinterface
`default_nettype wire

// ===== src/line_edit_input_ring_top.sv =====
// top level: line editing input ring with config registers and result register
// result valid rises in the cycle after an input transfer
// throughput: one item per cycle, set by the single result register and one ram port each way
// a stalled result holds the input side unless out ready frees the register that cycle
// reset: synchronous active low; clears pointers, result valid and restores the codes
// ring contents are not cleared by reset
`default_nettype none
module line_edit_input_ring_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  lier_in_if.sink                             in_ch,
  lier_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [lier_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lier_pkg::CHAR_W-1:0]    cfg_wdata
);

  lier_pkg::char_t    backspace_r;
  lier_pkg::char_t    newline_r;
  lier_pkg::mem_req_t mem_req;
  lier_pkg::result_t  result;
  lier_pkg::result_t  result_r;
  lier_pkg::char_t    rd_data;
  logic               out_valid_r;
  logic               accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backspace_r <= lier_pkg::BACKSPACE_RESET;
      newline_r   <= lier_pkg::NEWLINE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lier_pkg::CFG_BACKSPACE: backspace_r <= cfg_wdata;
        lier_pkg::CFG_NEWLINE:   newline_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lier_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .operation      (in_ch.operation),
    .key_char       (in_ch.key_char),
    .backspace_code (backspace_r),
    .newline_code   (newline_r),
    .mem_req        (mem_req),
    .result         (result)
  );

  lier_ram #(
    .DEPTH (lier_pkg::RING_DEPTH),
    .WIDTH (lier_pkg::CHAR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.echo_valid       = result_r.echo_valid;
  assign out_ch.echo_char        = result_r.echo_char;
  assign out_ch.key_dropped      = result_r.key_dropped;
  assign out_ch.read_valid       = result_r.read_valid;
  assign out_ch.read_char        = result_r.read_valid ? rd_data : '0;
  assign out_ch.read_end_of_line = result_r.read_valid && (rd_data == newline_r);

endmodule
`default_nettype wire

// ===== src/lier_ram.sv =====
// simple dual-port ram with registered read data
`default_nettype none
module lier_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 7
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/lier_ctrl.sv =====
// edit, commit and read pointers with the per-item line editing decisions
`default_nettype none
module lier_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic                       operation,
  input  wire logic [lier_pkg::KEY_W-1:0] key_char,
  input  wire lier_pkg::char_t            backspace_code,
  input  wire lier_pkg::char_t            newline_code,
  output lier_pkg::mem_req_t              mem_req,
  output lier_pkg::result_t               result
);

  lier_pkg::ptr_t  edit_r, edit_nxt;
  lier_pkg::ptr_t  commit_r, commit_nxt;
  lier_pkg::ptr_t  read_r, read_nxt;
  lier_pkg::ptr_t  edit_next;
  lier_pkg::char_t key7;
  logic            ignored;

  assign key7      = key_char[lier_pkg::CHAR_W-1:0];
  assign ignored   = (key_char == '0) || key_char[lier_pkg::KEY_W-1];
  assign edit_next = lier_pkg::ring_next(edit_r);

  always_comb begin
    edit_nxt           = edit_r;
    commit_nxt         = commit_r;
    read_nxt           = read_r;
    mem_req.wr_en      = 1'b0;
    mem_req.wr_addr    = edit_r;
    mem_req.wr_data    = key7;
    mem_req.rd_en      = 1'b0;
    mem_req.rd_addr    = read_r;
    result.echo_valid  = 1'b0;
    result.echo_char   = '0;
    result.key_dropped = 1'b0;
    result.read_valid  = 1'b0;
    if (operation == lier_pkg::OP_KEY) begin
      if (!ignored) begin
        if (key7 == backspace_code) begin
          if (edit_r != commit_r) begin
            edit_nxt          = lier_pkg::ring_prev(edit_r);
            result.echo_valid = 1'b1;
            result.echo_char  = key7;
          end
        end else if (edit_next == read_r) begin
          result.key_dropped = 1'b1;
        end else begin
          mem_req.wr_en     = accept;
          edit_nxt          = edit_next;
          result.echo_valid = 1'b1;
          result.echo_char  = key7;
          if (key7 == newline_code) begin
            commit_nxt = edit_next;
          end
        end
      end
    end else if (read_r != commit_r) begin
      mem_req.rd_en     = accept;
      read_nxt          = lier_pkg::ring_next(read_r);
      result.read_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edit_r   <= '0;
      commit_r <= '0;
      read_r   <= '0;
    end else if (accept) begin
      edit_r   <= edit_nxt;
      commit_r <= commit_nxt;
      read_r   <= read_nxt;
    end
  end

endmodule
`default_nettype wire
